/* design/drive_ratio_limiter_macros.svh */
// Assertion helpers used by the checker file of the drive ratio limiter.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef DRIVE_RATIO_LIMITER_MACROS_SVH
`define DRIVE_RATIO_LIMITER_MACROS_SVH

`define DRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define DRL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/drl_pkg.sv */
`timescale 1ns / 1ps

package drl_pkg;

  localparam int TANH_ENTRIES_DEF = 256;

  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 31;
  localparam int PROD_W  = 57;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_SETX,
    OP_MUL_POS,
    OP_SPLIT,
    OP_LATCH_LO,
    OP_MUL_DF,
    OP_INTERP,
    OP_MUL_TA,
    OP_ACC_TA,
    OP_MUL_TB,
    OP_ACC_TB,
    OP_LOAD_NUM,
    OP_DIV_MUL,
    OP_DIV_QUO,
    OP_DIV_MULD,
    OP_DIV_COR,
    OP_RATIO_SET,
    OP_LOAD_CAPS,
    OP_RATIO_MIN,
    OP_LOWSPD,
    OP_LOAD_STEER,
    OP_STEER_SET,
    OP_NORM_INIT,
    OP_LOAD_CAPN,
    OP_FINISH
  } op_e;

  typedef enum logic [1:0] {
    DIV_1000,
    DIV_5,
    DIV_15
  } div_e;

  typedef struct packed {
    op_e  op;
    div_e dsel;
    logic rom_inc;
    logic load;
  } dp_ctrl_t;

  typedef struct packed {
    logic safe;
    logic no_cap;
    logic first_pass;
  } dp_status_t;

endpackage

/* design/drl_datapath.sv */
`timescale 1ns / 1ps

module drl_datapath #(
  parameter int TANH_ENTRIES = drl_pkg::TANH_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  drl_pkg::dp_ctrl_t   ctrl_i,
  output drl_pkg::dp_status_t status_o,
  input  logic [15:0]         speed_mag_i,
  input  logic signed [15:0]  speed_delta_i,
  input  logic signed [15:0]  pitch_rate_i,
  input  logic signed [15:0]  pitch_angle_i,
  input  logic signed [9:0]   throttle_cmd_i,
  output logic [15:0]         accel_ratio_o,
  output logic [15:0]         steer_ratio_o,
  output logic signed [1:0]   drive_dir_o
);

  import drl_pkg::*;

  localparam int IdxW = $clog2(TANH_ENTRIES);
  localparam logic [63:0] StepH = (64'd4 << 30) / (TANH_ENTRIES - 1);
  localparam logic [15:0] OneQ15 = 16'd32768;

  // The table points are worked out once at elaboration by the tanh addition rule.
  function automatic logic [TANH_ENTRIES*16-1:0] build_tab();
    logic [TANH_ENTRIES*16-1:0] tab;
    logic [63:0] h2, h3, h5, h7, th, t, num, den, quo, rem;
    tab = '0;
    h2  = (StepH * StepH) >> 30;
    h3  = (h2 * StepH) >> 30;
    h5  = (h3 * h2) >> 30;
    h7  = (h5 * h2) >> 30;
    th  = StepH - h3 / 64'd3 + (64'd2 * h5) / 64'd15 - (64'd17 * h7) / 64'd315;
    t   = '0;
    for (int k = 0; k < TANH_ENTRIES; k++) begin
      tab[k*16 +: 16] = 16'((t + 64'd16384) >> 15);
      num = (t + th) << 30;
      den = (64'd1 << 30) + ((t * th) >> 30);
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem    = rem - den;
          quo[b] = 1'b1;
        end
      end
      t = quo;
    end
    return tab;
  endfunction

  localparam logic [TANH_ENTRIES*16-1:0] TanhTab = build_tab();

  function automatic logic signed [MUL_B_W-1:0] div_recip(div_e d);
    logic signed [MUL_B_W-1:0] m;
    unique case (d)
      DIV_1000: m = 31'sd4294967;
      DIV_5:    m = 31'sd858993459;
      DIV_15:   m = 31'sd286331153;
      default:  m = '0;
    endcase
    return m;
  endfunction

  function automatic logic signed [MUL_B_W-1:0] div_const(div_e d);
    logic signed [MUL_B_W-1:0] c;
    unique case (d)
      DIV_1000: c = 31'sd1000;
      DIV_5:    c = 31'sd5;
      DIV_15:   c = 31'sd15;
      default:  c = 31'sd1;
    endcase
    return c;
  endfunction

  function automatic logic [23:0] clamp_n(logic signed [24:0] v, logic signed [24:0] lo,
                                          logic signed [24:0] hi);
    logic signed [24:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r[23:0];
  endfunction

  logic [15:0]              s_q;
  logic signed [15:0]       ds_q, pr_q, p_q;
  logic signed [9:0]        cmd_q;
  logic                     safe_q;
  logic signed [9:0]        prev_q;
  logic signed [1:0]        dir_q;
  logic signed [17:0]       x_q;
  logic                     sign_q, pass_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [IdxW-1:0]          idx_q;
  logic [14:0]              frac_q;
  logic [15:0]              rom_q, tlo_q;
  logic signed [16:0]       ta_q, tb_q;
  logic signed [24:0]       acc_q;
  logic [23:0]              n_q, q_q;
  logic [15:0]              ratio_q, steer_q;
  logic [15:0]              accel_out_q, steer_out_q;
  logic signed [1:0]        dir_out_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_en;
  logic signed [PROD_W-1:0]  prod_d;
  logic [IdxW-1:0]           rom_addr;
  logic [17:0]               abs_x;
  logic [14:0]               pos_hi;
  logic                      sat;
  logic signed [16:0]        tdiff, tval, tval_s;
  logic signed [31:0]        step_r;
  logic signed [25:0]        div_rem;
  logic                      cap_pos, cap_neg;
  logic signed [24:0]        p64, cap_safe, cap_norm, steer_raw;
  logic signed [1:0]         dir_n;
  logic                      override;

  assign cap_pos = (cmd_q > 10'sd50) && (pr_q < -16'sd1000);
  assign cap_neg = (cmd_q < -10'sd50) && (pr_q > 16'sd1000);

  assign status_o.safe       = safe_q;
  assign status_o.no_cap     = !(cap_pos || cap_neg);
  assign status_o.first_pass = !pass_q;

  assign rom_addr = idx_q + IdxW'(ctrl_i.rom_inc);

  always_ff @(posedge clk_i) begin
    rom_q <= TanhTab[{rom_addr, 4'b0000} +: 16];
  end

  always_comb begin
    abs_x     = x_q[17] ? 18'(-x_q) : 18'(x_q);
    tdiff     = $signed({1'b0, rom_q}) - $signed({1'b0, tlo_q});
    mul_en    = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    unique case (ctrl_i.op)
      OP_MUL_POS: begin
        mul_a = MUL_A_W'($signed({1'b0, abs_x}));
        mul_b = MUL_B_W'(TANH_ENTRIES - 1);
      end
      OP_MUL_DF: begin
        mul_a = MUL_A_W'(tdiff);
        mul_b = MUL_B_W'($signed({1'b0, frac_q}));
      end
      OP_MUL_TA: begin
        mul_a = MUL_A_W'(ta_q);
        mul_b = 31'sd125;
      end
      OP_MUL_TB: begin
        mul_a = MUL_A_W'(tb_q);
        mul_b = 31'sd100;
      end
      OP_DIV_MUL: begin
        mul_a = $signed({2'b00, n_q});
        mul_b = div_recip(ctrl_i.dsel);
      end
      OP_DIV_MULD: begin
        mul_a = $signed({2'b00, q_q});
        mul_b = div_const(ctrl_i.dsel);
      end
      default: mul_en = 1'b0;
    endcase
    prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    pos_hi    = prod_q[28:14];
    sat       = pos_hi >= 15'(TANH_ENTRIES - 1);
    step_r    = ($signed(prod_q[31:0]) + 32'sd8192) >>> 14;
    tval      = $signed({1'b0, tlo_q}) + 17'(step_r);
    tval_s    = sign_q ? -tval : tval;
    div_rem   = $signed({2'b00, n_q}) - $signed(prod_q[25:0]);
    p64       = {{3{p_q[15]}}, p_q, 6'b000000};
    cap_safe  = cap_pos ? 25'sd180224 + p64 : 25'sd180224 - p64;
    cap_norm  = cap_pos ? 25'sd589824 + p64 : 25'sd589824 - p64;
    steer_raw = 25'sd196608 - $signed({7'b0000000, s_q, 2'b00});
  end

  always_comb begin
    dir_n = dir_q;
    if ((s_q > 16'd2048) && ((ds_q > 16'sd2048) || (dir_q == 2'sd0))) begin
      if (prev_q > 10'sd30) begin
        dir_n = 2'sd1;
      end else if (prev_q < -10'sd30) begin
        dir_n = -2'sd1;
      end
    end
    if (s_q <= 16'd40) begin
      dir_n = 2'sd0;
    end
    override = (cmd_q != 10'sd0) && (dir_n != 2'sd0) && (cmd_q[9] != dir_n[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safe_q <= 1'b0;
      prev_q <= '0;
      dir_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        safe_q <= cfg_wdata_i;
      end
      if (ctrl_i.op == OP_FINISH) begin
        prev_q <= cmd_q;
        dir_q  <= dir_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      s_q   <= speed_mag_i;
      ds_q  <= speed_delta_i;
      pr_q  <= pitch_rate_i;
      p_q   <= pitch_angle_i;
      cmd_q <= throttle_cmd_i;
    end
    if (mul_en) begin
      prod_q <= prod_d;
    end
    unique case (ctrl_i.op)
      OP_SETX: begin
        x_q    <= 18'sd8192 - $signed({2'b00, s_q});
        pass_q <= 1'b0;
      end
      OP_MUL_POS:  sign_q <= x_q[17];
      OP_SPLIT: begin
        idx_q  <= sat ? IdxW'(TANH_ENTRIES - 2) : pos_hi[IdxW-1:0];
        frac_q <= sat ? 15'd16384 : {1'b0, prod_q[13:0]};
      end
      OP_LATCH_LO: tlo_q <= rom_q;
      OP_INTERP: begin
        if (!pass_q) begin
          ta_q <= tval_s;
          x_q  <= 18'sd4096 - $signed({1'b0, s_q, 1'b0});
        end else begin
          tb_q <= tval_s;
        end
        pass_q <= !pass_q;
      end
      OP_ACC_TA:    acc_q <= 25'sd5734400 + 25'(prod_q);
      OP_ACC_TB:    acc_q <= acc_q - 25'(prod_q);
      OP_LOAD_NUM:  n_q <= (acc_q[24] ? 24'd0 : acc_q[23:0]) + 24'd500;
      OP_DIV_QUO:   q_q <= prod_q[55:32];
      OP_DIV_COR: begin
        if (div_rem >= 26'(div_const(ctrl_i.dsel))) begin
          q_q <= q_q + 24'd1;
        end
      end
      OP_RATIO_SET: ratio_q <= q_q[15:0];
      OP_LOAD_CAPS: n_q <= clamp_n(cap_safe, 25'sd32768, 25'sd163840);
      OP_RATIO_MIN: begin
        if (q_q[15:0] < ratio_q) begin
          ratio_q <= q_q[15:0];
        end
      end
      OP_LOWSPD: begin
        if (s_q <= 16'd286) begin
          ratio_q <= OneQ15;
        end
      end
      OP_LOAD_STEER: n_q <= clamp_n(steer_raw, 25'sd49152, 25'sd163840);
      OP_STEER_SET:  steer_q <= q_q[15:0];
      OP_NORM_INIT: begin
        steer_q <= OneQ15;
        ratio_q <= OneQ15;
      end
      OP_LOAD_CAPN: n_q <= clamp_n(cap_norm, 25'sd98304, 25'sd491520);
      OP_FINISH: begin
        accel_out_q <= override ? OneQ15 : ratio_q;
        steer_out_q <= steer_q;
        dir_out_q   <= dir_n;
      end
      default: ;
    endcase
  end

  assign accel_ratio_o = accel_out_q;
  assign steer_ratio_o = steer_out_q;
  assign drive_dir_o   = dir_out_q;

endmodule

/* design/drl_seq.sv */
`timescale 1ns / 1ps

module drl_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  drl_pkg::dp_status_t status_i,
  output drl_pkg::dp_ctrl_t   ctrl_o
);

  import drl_pkg::*;

  localparam int PcW = 6;
  localparam logic [PcW-1:0] PcLoop   = 6'd1;
  localparam logic [PcW-1:0] PcLowspd = 6'd23;
  localparam logic [PcW-1:0] PcNorm   = 6'd30;
  localparam logic [PcW-1:0] PcFin    = 6'd37;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_NOT_SAFE,
    JMP_NO_CAP,
    JMP_FIRST
  } jmp_e;

  typedef struct packed {
    op_e            op;
    div_e           dsel;
    logic           rom_inc;
    jmp_e           jmp;
    logic [PcW-1:0] target;
  } ucw_t;

  function automatic ucw_t uw(op_e op, div_e dsel, logic inc, jmp_e jmp, logic [PcW-1:0] tgt);
    ucw_t w;
    w.op      = op;
    w.dsel    = dsel;
    w.rom_inc = inc;
    w.jmp     = jmp;
    w.target  = tgt;
    return w;
  endfunction

  // Safe mode runs the tanh lookup twice, then two or three divisions by constants.
  function automatic ucw_t ucode(logic [PcW-1:0] pc);
    ucw_t w;
    unique case (pc)
      6'd0:  w = uw(OP_SETX,       DIV_1000, 1'b0, JMP_NOT_SAFE, PcNorm);
      6'd1:  w = uw(OP_MUL_POS,    DIV_1000, 1'b0, JMP_NONE,     '0);
      6'd2:  w = uw(OP_SPLIT,      DIV_1000, 1'b0, JMP_NONE,     '0);
      6'd3:  w = uw(OP_NOP,        DIV_1000, 1'b0, JMP_NONE,     '0);
      6'd4:  w = uw(OP_LATCH_LO,   DIV_1000, 1'b1, JMP_NONE,     '0);
      6'd5:  w = uw(OP_MUL_DF,     DIV_1000, 1'b0, JMP_NONE,     '0);
      6'd6:  w = uw(OP_INTERP,     DIV_1000, 1'b0, JMP_FIRST,    PcLoop);
      6'd7:  w = uw(OP_MUL_TA,     DIV_1000, 1'b0, JMP_NONE,     '0);
      6'd8:  w = uw(OP_ACC_TA,     DIV_1000, 1'b0, JMP_NONE,     '0);
      6'd9:  w = uw(OP_MUL_TB,     DIV_1000, 1'b0, JMP_NONE,     '0);
      6'd10: w = uw(OP_ACC_TB,     DIV_1000, 1'b0, JMP_NONE,     '0);
      6'd11: w = uw(OP_LOAD_NUM,   DIV_1000, 1'b0, JMP_NONE,     '0);
      6'd12: w = uw(OP_DIV_MUL,    DIV_1000, 1'b0, JMP_NONE,     '0);
      6'd13: w = uw(OP_DIV_QUO,    DIV_1000, 1'b0, JMP_NONE,     '0);
      6'd14: w = uw(OP_DIV_MULD,   DIV_1000, 1'b0, JMP_NONE,     '0);
      6'd15: w = uw(OP_DIV_COR,    DIV_1000, 1'b0, JMP_NONE,     '0);
      6'd16: w = uw(OP_RATIO_SET,  DIV_1000, 1'b0, JMP_NO_CAP,   PcLowspd);
      6'd17: w = uw(OP_LOAD_CAPS,  DIV_5,    1'b0, JMP_NONE,     '0);
      6'd18: w = uw(OP_DIV_MUL,    DIV_5,    1'b0, JMP_NONE,     '0);
      6'd19: w = uw(OP_DIV_QUO,    DIV_5,    1'b0, JMP_NONE,     '0);
      6'd20: w = uw(OP_DIV_MULD,   DIV_5,    1'b0, JMP_NONE,     '0);
      6'd21: w = uw(OP_DIV_COR,    DIV_5,    1'b0, JMP_NONE,     '0);
      6'd22: w = uw(OP_RATIO_MIN,  DIV_5,    1'b0, JMP_NONE,     '0);
      6'd23: w = uw(OP_LOWSPD,     DIV_5,    1'b0, JMP_NONE,     '0);
      6'd24: w = uw(OP_LOAD_STEER, DIV_5,    1'b0, JMP_NONE,     '0);
      6'd25: w = uw(OP_DIV_MUL,    DIV_5,    1'b0, JMP_NONE,     '0);
      6'd26: w = uw(OP_DIV_QUO,    DIV_5,    1'b0, JMP_NONE,     '0);
      6'd27: w = uw(OP_DIV_MULD,   DIV_5,    1'b0, JMP_NONE,     '0);
      6'd28: w = uw(OP_DIV_COR,    DIV_5,    1'b0, JMP_NONE,     '0);
      6'd29: w = uw(OP_STEER_SET,  DIV_5,    1'b0, JMP_ALWAYS,   PcFin);
      6'd30: w = uw(OP_NORM_INIT,  DIV_15,   1'b0, JMP_NO_CAP,   PcFin);
      6'd31: w = uw(OP_LOAD_CAPN,  DIV_15,   1'b0, JMP_NONE,     '0);
      6'd32: w = uw(OP_DIV_MUL,    DIV_15,   1'b0, JMP_NONE,     '0);
      6'd33: w = uw(OP_DIV_QUO,    DIV_15,   1'b0, JMP_NONE,     '0);
      6'd34: w = uw(OP_DIV_MULD,   DIV_15,   1'b0, JMP_NONE,     '0);
      6'd35: w = uw(OP_DIV_COR,    DIV_15,   1'b0, JMP_NONE,     '0);
      6'd36: w = uw(OP_RATIO_SET,  DIV_15,   1'b0, JMP_NONE,     '0);
      6'd37: w = uw(OP_FINISH,     DIV_15,   1'b0, JMP_NONE,     '0);
      default: w = uw(OP_NOP,      DIV_1000, 1'b0, JMP_ALWAYS,   PcFin);
    endcase
    return w;
  endfunction

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic           out_valid_q, out_valid_d;
  ucw_t           cur;
  logic           accept, out_free, hold, run, taken;

  assign cur      = ucode(pc_q);
  assign accept   = in_valid_i && !busy_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign hold     = busy_q && (cur.op == OP_FINISH) && !out_free;
  assign run      = busy_q && !hold;

  always_comb begin
    unique case (cur.jmp)
      JMP_NONE:     taken = 1'b0;
      JMP_ALWAYS:   taken = 1'b1;
      JMP_NOT_SAFE: taken = !status_i.safe;
      JMP_NO_CAP:   taken = status_i.no_cap;
      JMP_FIRST:    taken = status_i.first_pass;
      default:      taken = 1'b0;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end else if (run) begin
      if (cur.op == OP_FINISH) begin
        busy_d      = 1'b0;
        out_valid_d = 1'b1;
      end else if (taken) begin
        pc_d = cur.target;
      end else begin
        pc_d = pc_q + 6'd1;
      end
    end
  end

  always_comb begin
    ctrl_o.op      = run ? cur.op : OP_NOP;
    ctrl_o.dsel    = cur.dsel;
    ctrl_o.rom_inc = cur.rom_inc;
    ctrl_o.load    = accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;

endmodule

/* design/drive_ratio_limiter.sv */
// A new beat is taken only while the block is idle: in_stall_o is high from an accepted
// beat until its result is written to the output registers, and a result waits there
// while out_stall_i holds the previous one. In safe mode the microcode program steps one
// shared multiplier through two tanh lookups and up to three divisions by constants; in
// normal mode it runs at most one division, and only when a hill cap applies.
// Reset: rst_ni is asynchronous and active low; it clears the sequencer, safe_mode, the
// direction memory and the previous throttle. The tanh table is a constant ROM.
`timescale 1ns / 1ps

module drive_ratio_limiter #(
  parameter int TANH_ENTRIES = drl_pkg::TANH_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        speed_mag_i,
  input  logic signed [15:0] speed_delta_i,
  input  logic signed [15:0] pitch_rate_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [9:0]  throttle_cmd_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        accel_ratio_o,
  output logic [15:0]        steer_ratio_o,
  output logic signed [1:0]  drive_dir_o
);

  import drl_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t status;

  drl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  drl_datapath #(
    .TANH_ENTRIES (TANH_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .speed_mag_i    (speed_mag_i),
    .speed_delta_i  (speed_delta_i),
    .pitch_rate_i   (pitch_rate_i),
    .pitch_angle_i  (pitch_angle_i),
    .throttle_cmd_i (throttle_cmd_i),
    .accel_ratio_o  (accel_ratio_o),
    .steer_ratio_o  (steer_ratio_o),
    .drive_dir_o    (drive_dir_o)
  );

endmodule

/* design/drl_checker.sv */
`timescale 1ns / 1ps
`include "drive_ratio_limiter_macros.svh"

module drl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [15:0]        accel_ratio_o,
  input logic [15:0]        steer_ratio_o,
  input logic signed [1:0]  drive_dir_o
);

  `DRL_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "no stall after an accepted beat")
  `DRL_ASSERT_IMP(a_result_needs_work, $rose(out_valid_o), $past(in_stall_o), "result without a beat in work")
  `DRL_ASSERT_IMP(a_done_gives_result, $fell(in_stall_o), out_valid_o, "work ended without a result")
  `DRL_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(accel_ratio_o) && $stable(steer_ratio_o) && $stable(drive_dir_o), "stalled result changed")

endmodule

bind drive_ratio_limiter drl_checker u_drl_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int TANH_N = drl_pkg::TANH_ENTRIES_DEF;
  localparam longint ONE_Q15 = 32768;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PERCENT = 36;

  typedef struct {
    logic [15:0]        speed;
    logic signed [15:0] delta;
    logic signed [15:0] rate;
    logic signed [15:0] angle;
    logic signed [9:0]  cmd;
  } tick_t;

  typedef struct {
    logic [15:0]        accel;
    logic [15:0]        steer;
    logic signed [1:0]  dir;
  } ratios_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [15:0]        speed_mag_i;
  logic signed [15:0] speed_delta_i;
  logic signed [15:0] pitch_rate_i;
  logic signed [15:0] pitch_angle_i;
  logic signed [9:0]  throttle_cmd_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [15:0]        accel_ratio_o;
  logic [15:0]        steer_ratio_o;
  logic signed [1:0]  drive_dir_o;

  int      tanh_rom [TANH_N];
  bit      safe_mode;
  longint  prev_cmd;
  longint  dir_mem;
  ratios_t pending_ratios [$];
  int      errors;
  bit      calm;
  int      hold_requests;
  int      holds_done;

  drive_ratio_limiter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .speed_mag_i   (speed_mag_i),
    .speed_delta_i (speed_delta_i),
    .pitch_rate_i  (pitch_rate_i),
    .pitch_angle_i (pitch_angle_i),
    .throttle_cmd_i(throttle_cmd_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .accel_ratio_o (accel_ratio_o),
    .steer_ratio_o (steer_ratio_o),
    .drive_dir_o   (drive_dir_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic void build_tanh_rom();
    longint unsigned h, h2, h3, h5, h7, th, t;
    h  = (64'd4 << 30) / 64'(TANH_N - 1);
    h2 = qmul(h, h);
    h3 = qmul(h2, h);
    h5 = qmul(h3, h2);
    h7 = qmul(h5, h2);
    th = h - h3 / 64'd3 + (64'd2 * h5) / 64'd15 - (64'd17 * h7) / 64'd315;
    t  = 0;
    for (int k = 0; k < TANH_N; k++) begin
      tanh_rom[k] = int'((t + 64'd16384) >> 15);
      t = ((t + th) << 30) / ((64'd1 << 30) + qmul(t, th));
    end
  endfunction

  function automatic longint tanh_q15(longint x);
    longint a, pos, i, f, d, v;
    a   = (x < 0) ? -x : x;
    pos = a * (TANH_N - 1);
    i   = pos >>> 14;
    f   = pos & 16383;
    if (i >= TANH_N - 1) begin
      v = tanh_rom[TANH_N - 1];
    end else begin
      d = longint'(tanh_rom[i + 1]) - longint'(tanh_rom[i]);
      v = longint'(tanh_rom[i]) + ((d * f + 8192) >>> 14);
    end
    return (x < 0) ? -v : v;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic ratios_t predict_ratios(tick_t t);
    longint  s, ds, pr, p, cmd, ratio, steer, num, c, cap;
    ratios_t r;
    s   = longint'(t.speed);
    ds  = longint'(t.delta);
    pr  = longint'(t.rate);
    p   = longint'(t.angle);
    cmd = longint'(t.cmd);
    cap = 0;
    if (cmd > 50 && pr < -1000) begin
      cap = 1;
    end else if (cmd < -50 && pr > 1000) begin
      cap = -1;
    end
    if (safe_mode) begin
      num = 175 * ONE_Q15 + 125 * tanh_q15(8192 - s) - 100 * tanh_q15(4096 - 2 * s);
      if (num < 0) begin
        num = 0;
      end
      ratio = (num + 500) / 1000;
      if (cap != 0) begin
        c = clamp(180224 + cap * 64 * p, 32768, 163840) / 5;
        if (c < ratio) begin
          ratio = c;
        end
      end
      if (s <= 286) begin
        ratio = ONE_Q15;
      end
      steer = clamp(196608 - 4 * s, 49152, 163840) / 5;
    end else begin
      steer = ONE_Q15;
      if (cap != 0) begin
        ratio = clamp(589824 + cap * 64 * p, 98304, 491520) / 15;
      end else begin
        ratio = ONE_Q15;
      end
    end
    if (s > 2048 && (ds > 2048 || dir_mem == 0)) begin
      if (prev_cmd > 30) begin
        dir_mem = 1;
      end
      if (prev_cmd < -30) begin
        dir_mem = -1;
      end
    end
    if (s <= 40) begin
      dir_mem = 0;
    end
    if (cmd * dir_mem < 0) begin
      ratio = ONE_Q15;
    end
    prev_cmd = cmd;
    r.accel = 16'(clamp(ratio, 0, 65535));
    r.steer = 16'(steer);
    r.dir   = 2'(dir_mem);
    return r;
  endfunction

  function automatic tick_t mk(int s, int ds, int pr, int p, int cmd);
    tick_t t;
    t.speed = 16'(s);
    t.delta = 16'(ds);
    t.rate  = 16'(pr);
    t.angle = 16'(p);
    t.cmd   = 10'(cmd);
    return t;
  endfunction

  function automatic int rand_sign();
    return ($urandom_range(1) == 1) ? 1 : -1;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    case ($urandom_range(9))
      0, 1: t.speed = 16'($urandom);
      2: t.speed = 16'($urandom_range(60));
      3: t.speed = 16'($urandom_range(300, 270));
      4: t.speed = 16'($urandom_range(2070, 2030));
      default: t.speed = 16'($urandom_range(20000));
    endcase
    case ($urandom_range(3))
      0: t.delta = 16'($urandom);
      1: t.delta = 16'($urandom_range(2100, 1990));
      default: t.delta = 16'(int'($urandom_range(12287)) - 4096);
    endcase
    case ($urandom_range(3))
      0: t.rate = 16'($urandom);
      1: t.rate = 16'(rand_sign() * int'($urandom_range(1020, 980)));
      default: t.rate = 16'(int'($urandom_range(8000)) - 4000);
    endcase
    if ($urandom_range(4) < 2) begin
      t.angle = 16'($urandom);
    end else begin
      t.angle = 16'(int'($urandom_range(16000)) - 8000);
    end
    case ($urandom_range(4))
      0, 1: t.cmd = 10'($urandom);
      2: t.cmd = 10'(rand_sign() * int'($urandom_range(55, 25)));
      default: t.cmd = 10'(int'($urandom_range(300)) - 150);
    endcase
    return t;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Entered and left at a falling edge; valid stays high after the beat, and a following
  // call lowers it only while it idles before its own beat.
  task automatic send_tick(tick_t t);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    speed_mag_i    <= t.speed;
    speed_delta_i  <= t.delta;
    pitch_rate_i   <= t.rate;
    pitch_angle_i  <= t.angle;
    throttle_cmd_i <= t.cmd;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    pending_ratios.push_back(predict_ratios(t));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (pending_ratios.size() != 0);
  endtask

  task automatic write_safe_mode(bit v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    safe_mode = v;
  endtask

  task automatic direction_run(output int sent);
    int    dir, len;
    tick_t t;
    dir  = rand_sign();
    len  = $urandom_range(6, 2);
    sent = 0;
    for (int k = 0; k < len; k++) begin
      t       = random_tick();
      t.speed = 16'($urandom_range(20000, 2049));
      t.cmd   = 10'(dir * int'($urandom_range(511, 31)));
      if ($urandom_range(1) == 1) begin
        t.delta = 16'($urandom_range(8000, 2049));
      end
      send_tick(t);
      sent++;
    end
    t       = random_tick();
    t.speed = 16'($urandom_range(20000, 2049));
    t.cmd   = 10'(-dir * int'($urandom_range(511, 51)));
    send_tick(t);
    sent++;
    if ($urandom_range(1) == 1) begin
      t       = random_tick();
      t.speed = 16'($urandom_range(40));
      send_tick(t);
      sent++;
    end
  endtask

  task automatic run_random(int count);
    int sent, n;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) < 4) begin
        direction_run(n);
        sent += n;
      end else begin
        send_tick(random_tick());
        sent++;
      end
    end
  endtask

  task automatic test_field_extremes();
    write_safe_mode(1'b1);
    send_tick(mk(0, -32768, -32768, -32768, -512));
    send_tick(mk(65535, 32767, 32767, 32767, 511));
    send_tick(mk(40, 0, 0, 0, 0));
    send_tick(mk(41, 0, 0, 0, 0));
    send_tick(mk(286, 0, 0, 0, 0));
    send_tick(mk(287, 0, 0, 0, 0));
    send_tick(mk(8192, 0, 0, 0, 0));
    send_tick(mk(2048, 2049, 0, 0, 31));
    drain_results();
  endtask

  task automatic test_hill_cap();
    write_safe_mode(1'b0);
    send_tick(mk(10000, 0, -1001, 32767, 51));
    send_tick(mk(10000, 0, 1001, -32768, -51));
    send_tick(mk(10000, 0, -1000, 5000, 51));
    send_tick(mk(10000, 0, 1001, 3000, -50));
    drain_results();
    write_safe_mode(1'b1);
    send_tick(mk(4000, 0, -32768, 2000, 511));
    send_tick(mk(4000, 0, 32767, 2000, -512));
    send_tick(mk(4000, 0, -5000, -32768, 100));
    drain_results();
  endtask

  task automatic test_direction_memory();
    write_safe_mode(1'b0);
    send_tick(mk(1000, 0, 0, 0, 100));
    send_tick(mk(3000, 0, 0, 0, 100));
    send_tick(mk(3000, 0, 0, 0, -100));
    send_tick(mk(3000, 3000, 0, 0, -100));
    send_tick(mk(3000, 0, 0, 0, 100));
    send_tick(mk(40, 0, 0, 0, 100));
    send_tick(mk(2049, 0, 0, 0, -31));
    drain_results();
  endtask

  task automatic test_random_settings();
    write_safe_mode(1'b0);
    run_random(300);
    drain_results();
    write_safe_mode(1'b1);
    run_random(300);
    drain_results();
  endtask

  task automatic test_steady_flow();
    calm = 1'b1;
    write_safe_mode(1'b0);
    run_random(150);
    drain_results();
    write_safe_mode(1'b1);
    run_random(150);
    drain_results();
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    hold_requests++;
    run_random(40);
    drain_results();
    calm = 1'b0;
  endtask

  task automatic test_sender_pause();
    write_safe_mode(1'b0);
    run_random(50);
    drain_results();
    run_random(50);
    drain_results();
  endtask

  initial begin : receiver_stalls
    int hold_left;
    hold_left   = 0;
    holds_done  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && holds_done != hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk_i) begin
    ratios_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_ratios.size() == 0) begin
        report_mismatch("result beat with nothing pending", accel_ratio_o, 0);
      end else begin
        want = pending_ratios.pop_front();
        if (accel_ratio_o !== want.accel) begin
          report_mismatch("accel_ratio", accel_ratio_o, want.accel);
        end
        if (steer_ratio_o !== want.steer) begin
          report_mismatch("steer_ratio", steer_ratio_o, want.steer);
        end
        if (drive_dir_o !== want.dir) begin
          report_mismatch("drive_dir", longint'(drive_dir_o), longint'(want.dir));
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 1'b0;
    in_valid_i     = 1'b0;
    speed_mag_i    = '0;
    speed_delta_i  = '0;
    pitch_rate_i   = '0;
    pitch_angle_i  = '0;
    throttle_cmd_i = '0;
    calm           = 1'b0;
    hold_requests  = 0;
    errors         = 0;
    safe_mode      = 1'b0;
    prev_cmd       = 0;
    dir_mem        = 0;
    build_tanh_rom();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_field_extremes();
    test_hill_cap();
    test_direction_memory();
    test_random_settings();
    test_steady_flow();
    test_backpressure();
    test_sender_pause();
    drain_results();
    repeat (50) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
